[rtl/core/arc_odometry_pose_integrator_assert.svh]
// Assertion helpers for the aop RTL.
// Both expect i_clk and i_rst_n in scope.
`ifndef ARC_ODOMETRY_POSE_INTEGRATOR_ASSERT_SVH
`define ARC_ODOMETRY_POSE_INTEGRATOR_ASSERT_SVH

// same-cycle implication
`define AOP_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("aop assertion failed");

// next-cycle implication
`define AOP_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("aop assertion failed");

`endif

[rtl/core/aop_pkg.sv]
package aop_pkg;

    localparam int OP_W     = 36;          // multiplier operand width
    localparam int PROD_W   = 2 * OP_W;    // product width
    localparam int NUM_W    = 56;          // divider dividend width
    localparam int DEN_W    = 20;          // divider divisor width
    localparam int CS_W     = 34;          // CORDIC x/y/z width
    localparam int CORDIC_N = 30;          // CORDIC iterations

    typedef logic signed [OP_W-1:0]   t_op;
    typedef logic signed [PROD_W-1:0] t_prod;
    typedef logic signed [NUM_W-1:0]  t_num;
    typedef logic signed [NUM_W:0]    t_quot;
    typedef logic signed [CS_W-1:0]   t_cs;

    localparam t_op ONE_Q30    = 36'sd1073741824;
    localparam t_op PI_Q30     = 36'sd3373259426;
    localparam t_op TWO_PI_Q28 = 36'sd1686629713;
    localparam t_op MEGA       = 36'sd1000000;
    localparam t_cs CORDIC_GAIN = 34'sd652032874;

    // atan(2^-i) in binary angle, 2^32 = full turn
    function automatic t_cs arctan(input logic [4:0] i);
        t_cs v;
        case (i)
            5'd0:  v = 34'sd536870912;
            5'd1:  v = 34'sd316933406;
            5'd2:  v = 34'sd167458907;
            5'd3:  v = 34'sd85004756;
            5'd4:  v = 34'sd42667331;
            5'd5:  v = 34'sd21354465;
            5'd6:  v = 34'sd10679838;
            5'd7:  v = 34'sd5340245;
            5'd8:  v = 34'sd2670163;
            5'd9:  v = 34'sd1335087;
            5'd10: v = 34'sd667544;
            5'd11: v = 34'sd333772;
            5'd12: v = 34'sd166886;
            5'd13: v = 34'sd83443;
            5'd14: v = 34'sd41722;
            5'd15: v = 34'sd20861;
            5'd16: v = 34'sd10430;
            5'd17: v = 34'sd5215;
            5'd18: v = 34'sd2608;
            5'd19: v = 34'sd1304;
            5'd20: v = 34'sd652;
            5'd21: v = 34'sd326;
            5'd22: v = 34'sd163;
            5'd23: v = 34'sd81;
            5'd24: v = 34'sd41;
            5'd25: v = 34'sd20;
            5'd26: v = 34'sd10;
            5'd27: v = 34'sd5;
            5'd28: v = 34'sd3;
            5'd29: v = 34'sd1;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

[rtl/core/aop_mul.sv]
// Bit-serial signed multiplier: one bit of b per cycle, sign bit subtracted.
module aop_mul (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  aop_pkg::t_op  i_a,
    input  aop_pkg::t_op  i_b,
    output logic          o_done,
    output aop_pkg::t_prod o_prod
);
    import aop_pkg::*;

    localparam int CNT_W = $clog2(OP_W);

    logic                    r_busy;
    logic                    r_done;
    logic [CNT_W-1:0]        r_cnt;
    t_op                     r_a;
    logic signed [OP_W:0]    r_hi;
    logic [OP_W-1:0]         r_lo;
    logic signed [OP_W:0]    w_a_ext;
    logic signed [OP_W:0]    w_add;
    logic signed [OP_W:0]    w_sum;
    logic                    w_last;

    assign w_last  = (r_cnt == CNT_W'(OP_W - 1));
    assign w_a_ext = (OP_W + 1)'(r_a);
    assign w_add   = !r_lo[0] ? '0 : (w_last ? -w_a_ext : w_a_ext);
    assign w_sum   = r_hi + w_add;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && w_last;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (w_last) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a  <= i_a;
            r_hi <= '0;
            r_lo <= i_b;
        end else if (r_busy) begin
            r_hi <= w_sum >>> 1;
            r_lo <= {w_sum[0], r_lo[OP_W-1:1]};
        end
    end

    assign o_done = r_done;
    assign o_prod = {r_hi[OP_W-1:0], r_lo};

endmodule

[rtl/core/aop_div.sv]
// Restoring divider, one quotient bit per cycle. Truncates toward zero.
module aop_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  aop_pkg::t_num                i_num,
    input  logic [aop_pkg::DEN_W-1:0]    i_den,
    output logic                         o_done,
    output aop_pkg::t_quot               o_quot
);
    import aop_pkg::*;

    localparam int CNT_W = $clog2(NUM_W);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [DEN_W-1:0]  r_den;
    logic [DEN_W-1:0]  r_rem;
    logic [NUM_W-1:0]  r_q;
    logic              r_neg;
    logic [DEN_W:0]    w_trial;
    logic              w_ge;
    logic              w_last;
    logic [NUM_W-1:0]  w_mag;

    assign w_last  = (r_cnt == CNT_W'(NUM_W - 1));
    assign w_trial = {r_rem, r_q[NUM_W-1]};
    assign w_ge    = (w_trial >= {1'b0, r_den});
    assign w_mag   = i_num[NUM_W-1] ? NUM_W'(-i_num) : NUM_W'(i_num);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && w_last;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (w_last) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_den <= i_den;
            r_rem <= '0;
            r_q   <= w_mag;
            r_neg <= i_num[NUM_W-1];
        end else if (r_busy) begin
            r_rem <= w_ge ? DEN_W'(w_trial - {1'b0, r_den}) : DEN_W'(w_trial);
            r_q   <= {r_q[NUM_W-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_neg ? -$signed({1'b0, r_q}) : $signed({1'b0, r_q});

endmodule

[rtl/core/aop_cordic.sv]
// Iterative rotation-mode CORDIC, one micro-rotation per cycle.
// Angles in quadrants 1 and 2 are turned by half a turn and the result negated.
module aop_cordic (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [31:0]  i_ang,
    output logic         o_done,
    output aop_pkg::t_cs o_cos,
    output aop_pkg::t_cs o_sin
);
    import aop_pkg::*;

    logic        r_busy;
    logic        r_done;
    logic [4:0]  r_i;
    logic        r_flip;
    t_cs         r_x;
    t_cs         r_y;
    t_cs         r_z;
    logic        w_flip;
    logic [31:0] w_ang;
    t_cs         w_xs;
    t_cs         w_ys;
    t_cs         w_at;
    logic        w_last;

    assign w_flip = (i_ang[31:30] == 2'b01) || (i_ang[31:30] == 2'b10);
    assign w_ang  = w_flip ? (i_ang + 32'h8000_0000) : i_ang;
    assign w_xs   = r_y >>> r_i;
    assign w_ys   = r_x >>> r_i;
    assign w_at   = arctan(r_i);
    assign w_last = (r_i == 5'(CORDIC_N - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_i    <= '0;
        end else begin
            r_done <= r_busy && w_last;
            if (i_start) begin
                r_busy <= 1'b1;
                r_i    <= '0;
            end else if (r_busy) begin
                r_i <= r_i + 1'b1;
                if (w_last) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_flip <= w_flip;
            r_x    <= CORDIC_GAIN;
            r_y    <= '0;
            r_z    <= CS_W'($signed(w_ang));
        end else if (r_busy) begin
            if (!r_z[CS_W-1]) begin
                r_x <= r_x - w_xs;
                r_y <= r_y + w_ys;
                r_z <= r_z - w_at;
            end else begin
                r_x <= r_x + w_xs;
                r_y <= r_y - w_ys;
                r_z <= r_z + w_at;
            end
        end
    end

    assign o_done = r_done;
    assign o_cos  = r_flip ? -r_x : r_x;
    assign o_sin  = r_flip ? -r_y : r_y;

endmodule

[rtl/core/arc_odometry_pose_integrator.sv]
// Channel   Dir  Handshake             Payload
// s_axis    in   tvalid/tready         tdata: side, forward, heading deltas, elapsed_us
//                                      tuser: bad_reading
// m_axis    out  tvalid/tready         tdata: x, y, heading, speed, turn rate
// cfg       in   i_cfg_we (no stall)   i_cfg_idx, i_cfg_data (24b offsets)
//
// One tick runs 18 products on the bit-serial multiplier, 7 quotients on the bit-serial
// divider and one CORDIC rotation; a zero elapsed_us skips the speed and turn-rate
// products and quotients.
// Synchronous active-low reset clears the pose, offsets and control state.
// s_axis_tready is high whenever no tick is in work; the finished result sits in
// the output register, so a new beat is taken while m_axis is stalled.
`include "arc_odometry_pose_integrator_assert.svh"

module arc_odometry_pose_integrator #(
    parameter int FRAC_BITS = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    // tdata: [31:0] side_delta, [63:32] forward_delta, [95:64] heading_delta,
    //        [115:96] elapsed_us, [119:116] zero
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [119:0]  s_axis_tdata,
    // tuser: [0] bad_reading
    input  logic [0:0]    s_axis_tuser,
    // tdata: [47:0] x_out, [95:48] y_out, [127:96] heading_out,
    //        [159:128] speed_out, [191:160] turn_rate_out
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [191:0]  m_axis_tdata,
    input  logic          i_cfg_we,
    input  logic [0:0]    i_cfg_idx,
    input  logic [23:0]   i_cfg_data
);
    import aop_pkg::*;

    localparam int RSH = 52 - FRAC_BITS;   // binary angle -> Q(FRAC_BITS+8) radians

    localparam logic [0:0] CFG_SIDE = 1'b0;
    localparam logic [0:0] CFG_FWD  = 1'b1;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_ISSUE = 2'd1;
    localparam logic [1:0] ST_WAIT  = 2'd2;
    localparam logic [1:0] ST_OUT   = 2'd3;

    // micro-program steps
    localparam logic [4:0] S_T    = 5'd0;   // t = h*pi
    localparam logic [4:0] S_U    = 5'd1;   // u = t*t
    localparam logic [4:0] S_D110 = 5'd2;
    localparam logic [4:0] S_M72  = 5'd3;
    localparam logic [4:0] S_D72  = 5'd4;
    localparam logic [4:0] S_M42  = 5'd5;
    localparam logic [4:0] S_D42  = 5'd6;
    localparam logic [4:0] S_M20  = 5'd7;
    localparam logic [4:0] S_D20  = 5'd8;
    localparam logic [4:0] S_M6   = 5'd9;
    localparam logic [4:0] S_D6   = 5'd10;  // k
    localparam logic [4:0] S_SIN2 = 5'd11;
    localparam logic [4:0] S_DXA  = 5'd12;
    localparam logic [4:0] S_DXB  = 5'd13;
    localparam logic [4:0] S_DYA  = 5'd14;
    localparam logic [4:0] S_DYB  = 5'd15;
    localparam logic [4:0] S_COR  = 5'd16;
    localparam logic [4:0] S_XA   = 5'd17;
    localparam logic [4:0] S_XB   = 5'd18;
    localparam logic [4:0] S_XW   = 5'd19;
    localparam logic [4:0] S_YA   = 5'd20;
    localparam logic [4:0] S_YB   = 5'd21;
    localparam logic [4:0] S_YW   = 5'd22;
    localparam logic [4:0] S_SPM  = 5'd23;
    localparam logic [4:0] S_SPD  = 5'd24;
    localparam logic [4:0] S_RM   = 5'd25;
    localparam logic [4:0] S_RMM  = 5'd26;
    localparam logic [4:0] S_RD   = 5'd27;

    localparam logic [1:0] K_MUL  = 2'd0;
    localparam logic [1:0] K_DIV  = 2'd1;
    localparam logic [1:0] K_COR  = 2'd2;
    localparam logic [1:0] K_CALC = 2'd3;

    function automatic logic [31:0] sat32(input t_quot q);
        logic [31:0] v;
        if (q > t_quot'(64'sd2147483647)) begin
            v = 32'h7FFF_FFFF;
        end else if (q < t_quot'(-64'sd2147483648)) begin
            v = 32'h8000_0000;
        end else begin
            v = q[31:0];
        end
        return v;
    endfunction

    // config registers
    logic signed [23:0] r_so;
    logic signed [23:0] r_fo;

    // control
    logic [1:0]  r_state;
    logic [4:0]  r_step;
    logic        r_out_valid;
    logic [191:0] r_out_data;

    // pose state
    logic signed [47:0] r_x;
    logic signed [47:0] r_y;
    logic [31:0]        r_hd;

    // tick payload and work registers
    logic signed [31:0] r_sd;
    logic signed [31:0] r_fd;
    logic signed [31:0] r_h;
    logic [19:0]        r_dt;
    t_op  r_t, r_u, r_p, r_k, r_sin2, r_dx, r_dy, r_r;
    t_cs  r_c, r_s;
    logic signed [63:0] r_acc;
    t_num r_num;
    logic [31:0] r_speed;
    logic [31:0] r_turn;

    // unit hookups
    logic        w_mul_start, w_div_start, w_cor_start;
    logic        w_mul_done, w_div_done, w_cor_done;
    t_op         w_mul_a, w_mul_b;
    t_prod       w_prod;
    logic [DEN_W-1:0] w_den;
    t_quot       w_quot;
    t_cs         w_cos, w_sin;
    logic [31:0] w_mid;

    logic [1:0]  w_kind;
    logic        w_wb;
    logic        w_unit_done;
    logic        w_load_out;
    t_op         w_sh30;
    t_prod       w_rsh;
    logic signed [33:0] w_acc_sh;
    t_quot       w_q_adj;
    t_quot       w_q256;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    assign w_sh30   = w_prod[OP_W+29:30];
    assign w_rsh    = w_prod >>> RSH;
    assign w_acc_sh = r_acc[63:30];
    assign w_mid    = r_hd + 32'(r_h >>> 1);
    // rate divide by 256 truncates toward zero
    assign w_q_adj  = w_quot + (w_quot[NUM_W] ? t_quot'(255) : t_quot'(0));
    assign w_q256   = w_q_adj >>> 8;

    always_comb begin
        unique case (r_step)
            S_D110, S_D72, S_D42, S_D20, S_D6, S_SPD, S_RD: w_kind = K_DIV;
            S_COR:       w_kind = K_COR;
            S_XW, S_YW:  w_kind = K_CALC;
            default:     w_kind = K_MUL;
        endcase
    end

    // multiplier operands
    always_comb begin
        unique case (r_step)
            S_T:    begin w_mul_a = OP_W'(r_h);  w_mul_b = PI_Q30;      end
            S_U:    begin w_mul_a = r_t;         w_mul_b = r_t;         end
            S_SIN2: begin w_mul_a = r_k;         w_mul_b = r_t <<< 1;   end
            S_DXA:  begin w_mul_a = r_k;         w_mul_b = OP_W'(r_sd); end
            S_DXB:  begin w_mul_a = r_sin2;      w_mul_b = OP_W'(r_so); end
            S_DYA:  begin w_mul_a = r_k;         w_mul_b = OP_W'(r_fd); end
            S_DYB:  begin w_mul_a = r_sin2;      w_mul_b = OP_W'(r_fo); end
            S_XA:   begin w_mul_a = OP_W'(r_c);  w_mul_b = r_dx;        end
            S_XB:   begin w_mul_a = OP_W'(r_s);  w_mul_b = r_dy;        end
            S_YA:   begin w_mul_a = OP_W'(r_c);  w_mul_b = r_dy;        end
            S_YB:   begin w_mul_a = OP_W'(r_s);  w_mul_b = r_dx;        end
            S_SPM:  begin w_mul_a = r_dy;        w_mul_b = MEGA;        end
            S_RM:   begin w_mul_a = OP_W'(r_h);  w_mul_b = TWO_PI_Q28;  end
            S_RMM:  begin w_mul_a = r_r;         w_mul_b = MEGA;        end
            default: begin w_mul_a = r_u;        w_mul_b = r_p;         end
        endcase
    end

    // divisor
    always_comb begin
        unique case (r_step)
            S_D110:  w_den = DEN_W'(110);
            S_D72:   w_den = DEN_W'(72);
            S_D42:   w_den = DEN_W'(42);
            S_D20:   w_den = DEN_W'(20);
            S_D6:    w_den = DEN_W'(6);
            default: w_den = r_dt;
        endcase
    end

    assign w_mul_start = (r_state == ST_ISSUE) && (w_kind == K_MUL);
    assign w_div_start = (r_state == ST_ISSUE) && (w_kind == K_DIV);
    assign w_cor_start = (r_state == ST_ISSUE) && (w_kind == K_COR);
    assign w_unit_done = w_mul_done || w_div_done || w_cor_done;
    assign w_wb = ((r_state == ST_WAIT) && w_unit_done)
               || ((r_state == ST_ISSUE) && (w_kind == K_CALC));
    assign w_load_out = (r_state == ST_OUT) && (!r_out_valid || m_axis_tready);

    aop_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mul_start),
        .i_a     (w_mul_a),
        .i_b     (w_mul_b),
        .o_done  (w_mul_done),
        .o_prod  (w_prod)
    );

    aop_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (r_num),
        .i_den   (w_den),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    aop_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_cor_start),
        .i_ang   (w_mid),
        .o_done  (w_cor_done),
        .o_cos   (w_cos),
        .o_sin   (w_sin)
    );

    // config port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_so <= '0;
            r_fo <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SIDE: r_so <= i_cfg_data;
                CFG_FWD:  r_fo <= i_cfg_data;
                default:  r_so <= r_so;
            endcase
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= S_T;
            r_out_valid <= 1'b0;
        end else begin
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_state <= ST_ISSUE;
                        r_step  <= S_T;
                    end
                end
                ST_ISSUE: begin
                    if (w_kind == K_CALC) begin
                        // zero elapsed time: rates stay zero, skip the rate products and divides
                        if ((r_step == S_YW) && (r_dt == '0)) begin
                            r_state <= ST_OUT;
                        end else begin
                            r_step <= r_step + 1'b1;
                        end
                    end else begin
                        r_state <= ST_WAIT;
                    end
                end
                ST_WAIT: begin
                    if (w_unit_done) begin
                        if (r_step == S_RD) begin
                            r_state <= ST_OUT;
                        end else begin
                            r_state <= ST_ISSUE;
                            r_step  <= r_step + 1'b1;
                        end
                    end
                end
                ST_OUT: begin
                    if (w_load_out) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // pose state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x  <= '0;
            r_y  <= '0;
            r_hd <= '0;
        end else if (w_wb) begin
            if (r_step == S_XW) begin
                r_x <= r_x + 48'(w_acc_sh);
            end
            if (r_step == S_YW) begin
                r_y  <= r_y + 48'(w_acc_sh);
                r_hd <= r_hd + r_h;
            end
        end
    end

    // payload capture and write-back
    always_ff @(posedge i_clk) begin
        if ((r_state == ST_IDLE) && s_axis_tvalid) begin
            // bad reading: all deltas count as zero
            r_sd <= s_axis_tuser[0] ? '0 : s_axis_tdata[31:0];
            r_fd <= s_axis_tuser[0] ? '0 : s_axis_tdata[63:32];
            r_h  <= s_axis_tuser[0] ? '0 : s_axis_tdata[95:64];
            r_dt <= s_axis_tdata[115:96];
        end
        if (w_wb) begin
            case (r_step)
                S_T:    r_t <= w_prod[OP_W+31:32];
                S_U: begin
                    r_u   <= w_sh30;
                    r_num <= NUM_W'(w_sh30);
                end
                S_M72, S_M42, S_M20, S_M6: r_num <= NUM_W'(w_sh30);
                S_D110, S_D72, S_D42, S_D20: r_p <= ONE_Q30 - w_quot[OP_W-1:0];
                S_D6:   r_k    <= ONE_Q30 - w_quot[OP_W-1:0];
                S_SIN2: r_sin2 <= w_sh30;
                S_DXA, S_DYA: r_acc <= 64'(w_sh30);
                S_DXB:  r_dx <= r_acc[OP_W-1:0] + w_sh30;
                S_DYB:  r_dy <= r_acc[OP_W-1:0] + w_sh30;
                S_COR: begin
                    r_c <= w_cos;
                    r_s <= w_sin;
                end
                S_XA, S_YA: r_acc <= w_prod[63:0];
                S_XB:   r_acc <= r_acc + w_prod[63:0];
                S_YB:   r_acc <= r_acc - w_prod[63:0];
                S_YW: begin
                    r_speed <= '0;
                    r_turn  <= '0;
                end
                S_SPM, S_RMM: r_num <= w_prod[NUM_W-1:0];
                S_SPD:  r_speed <= sat32(w_quot);
                S_RM:   r_r     <= w_rsh[OP_W-1:0];
                S_RD:   r_turn  <= sat32(w_q256);
                default: r_acc  <= r_acc;
            endcase
        end
        if (w_load_out) begin
            r_out_data <= {r_turn, r_speed, r_hd, r_y, r_x};
        end
    end

    `AOP_ASSERT_NXT(a_accept_starts, s_axis_tvalid && s_axis_tready, (r_state == ST_ISSUE) && (r_step == S_T))
    `AOP_ASSERT_IMP(a_one_unit, 1'b1, $onehot0({w_mul_start, w_div_start, w_cor_start}))
    `AOP_ASSERT_IMP(a_div_nonzero, w_div_start, w_den != '0)

endmodule

[verif/arc_odometry_pose_integrator_tb.sv]
`timescale 1ns / 1ps

module arc_odometry_pose_integrator_tb;

    // register map of the config port
    typedef enum logic [0:0] {
        REG_SIDE_OFFSET    = 1'b0,
        REG_FORWARD_OFFSET = 1'b1
    } reg_idx_e;

    typedef struct {
        logic [31:0] side_delta;
        logic [31:0] forward_delta;
        logic [31:0] heading_delta;
        logic [19:0] elapsed_us;
        logic        bad_reading;
    } tick_t;

    typedef struct {
        logic [47:0] x;
        logic [47:0] y;
        logic [31:0] heading;
        logic [31:0] speed;
        logic [31:0] turn_rate;
    } pose_t;

    // Tracks the pose the block should report and checks each output beat.
    class pose_scoreboard;
        longint      side_off;
        longint      fwd_off;
        logic [47:0] x_acc;
        logic [47:0] y_acc;
        logic [31:0] hdg_acc;
        pose_t       pose_q[$];
        int          errors;

        localparam longint ONE_Q30   = 64'sd1073741824;
        localparam longint PI_Q30    = 64'sd3373259426;
        localparam longint TWOPI_Q28 = 64'sd1686629713;
        localparam longint GAIN      = 64'sd652032874;
        longint atan_lut[30] = '{
            536870912, 316933406, 167458907, 85004756, 42667331, 21354465, 10679838,
            5340245, 2670163, 1335087, 667544, 333772, 166886, 83443, 41722, 20861,
            10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10, 5, 3, 1};

        function new();
            side_off = 0;
            fwd_off  = 0;
            x_acc    = '0;
            y_acc    = '0;
            hdg_acc  = '0;
            errors   = 0;
        endfunction

        function void set_offset(reg_idx_e idx, logic [23:0] val);
            if (idx == REG_SIDE_OFFSET) side_off = longint'($signed(val));
            else                        fwd_off  = longint'($signed(val));
        endfunction

        function int pending();
            return pose_q.size();
        endfunction

        // 30-step CORDIC in rotation mode, Q30 out
        function void rotate_unit(logic [31:0] ang, output longint c, output longint s);
            logic   flip;
            longint x;
            longint y;
            longint z;
            longint xs;
            longint ys;
            flip = (ang[31:30] == 2'd1) || (ang[31:30] == 2'd2);
            if (flip) ang = ang + 32'h8000_0000;
            z = longint'($signed(ang));
            x = GAIN;
            y = 0;
            for (int i = 0; i < 30; i++) begin
                xs = y >>> i;
                ys = x >>> i;
                if (z >= 0) begin
                    x = x - xs; y = y + ys; z = z - atan_lut[i];
                end else begin
                    x = x + xs; y = y - ys; z = z + atan_lut[i];
                end
            end
            c = flip ? -x : x;
            s = flip ? -y : y;
        endfunction

        function longint sat32(longint v);
            if (v > 64'sd2147483647) return 64'sd2147483647;
            if (v < -64'sd2147483648) return -64'sd2147483648;
            return v;
        endfunction

        // accepted input beat: advance the pose and queue what should come out
        function void note_tick(tick_t t);
            longint sd, fd, h, dt, th, u, p, k, sin2, dx, dy, c, s, r;
            longint speed;
            longint turn;
            logic [31:0] mid;
            pose_t  e;
            sd = longint'($signed(t.side_delta));
            fd = longint'($signed(t.forward_delta));
            h  = longint'($signed(t.heading_delta));
            dt = longint'(t.elapsed_us);
            speed = 0;
            turn  = 0;
            if (t.bad_reading) begin
                sd = 0; fd = 0; h = 0;
            end
            // sinc(dh/2) by Taylor series, Q30
            th = (h * PI_Q30) >>> 32;
            u  = (th * th) >>> 30;
            p  = ONE_Q30 - u / 110;
            p  = ONE_Q30 - ((u * p) >>> 30) / 72;
            p  = ONE_Q30 - ((u * p) >>> 30) / 42;
            p  = ONE_Q30 - ((u * p) >>> 30) / 20;
            k  = ONE_Q30 - ((u * p) >>> 30) / 6;
            sin2 = (k * (2 * th)) >>> 30;
            dx = ((k * sd) >>> 30) + ((sin2 * side_off) >>> 30);
            dy = ((k * fd) >>> 30) + ((sin2 * fwd_off) >>> 30);
            mid = hdg_acc + 32'(h >>> 1);
            rotate_unit(mid, c, s);
            x_acc   = x_acc + 48'((c * dx + s * dy) >>> 30);
            y_acc   = y_acc + 48'((c * dy - s * dx) >>> 30);
            hdg_acc = hdg_acc + 32'(h);
            if (dt != 0) begin
                r     = (h * TWOPI_Q28) >>> 36;
                speed = dy * 1000000 / dt;
                turn  = (r * 1000000 / dt) / 256;
            end
            e.x         = x_acc;
            e.y         = y_acc;
            e.heading   = hdg_acc;
            e.speed     = 32'(sat32(speed));
            e.turn_rate = 32'(sat32(turn));
            pose_q.push_back(e);
        endfunction

        function void check_pose(logic [191:0] d);
            pose_t e;
            if (pose_q.size() == 0) begin
                $display("%0t: unexpected output beat %h", $time, d);
                errors++;
                return;
            end
            e = pose_q.pop_front();
            if (d[47:0] !== e.x) begin
                $display("%0t: x exp %h got %h", $time, e.x, d[47:0]);
                errors++;
            end
            if (d[95:48] !== e.y) begin
                $display("%0t: y exp %h got %h", $time, e.y, d[95:48]);
                errors++;
            end
            if (d[127:96] !== e.heading) begin
                $display("%0t: heading exp %h got %h", $time, e.heading, d[127:96]);
                errors++;
            end
            if (d[159:128] !== e.speed) begin
                $display("%0t: speed exp %h got %h", $time, e.speed, d[159:128]);
                errors++;
            end
            if (d[191:160] !== e.turn_rate) begin
                $display("%0t: turn rate exp %h got %h", $time, e.turn_rate, d[191:160]);
                errors++;
            end
        endfunction
    endclass

    localparam int STALL_LIMIT = 40000;

    logic           i_clk;
    logic           i_rst_n;
    logic           s_axis_tvalid;
    logic           s_axis_tready;
    logic [119:0]   s_axis_tdata;   // side, forward, heading deltas, elapsed_us, pad
    logic [0:0]     s_axis_tuser;   // bad_reading
    logic           m_axis_tvalid;
    logic           m_axis_tready;
    logic [191:0]   m_axis_tdata;   // x, y, heading, speed, turn rate
    logic           i_cfg_we;
    logic [0:0]     i_cfg_idx;
    logic [23:0]    i_cfg_data;

    pose_scoreboard sb;
    logic           calm_tx;        // no source gaps
    logic           calm_rx;        // no sink stalls
    int             quiet_cycles;

    arc_odometry_pose_integrator DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // sink backpressure, ~27% stalls unless calm
    always @(posedge i_clk) begin
        m_axis_tready <= calm_rx ? 1'b1 : ($urandom_range(99) >= 27);
    end

    // Handshake outcome is settled between edges, so look at negedge:
    // a beat seen here is taken at the next rising edge.
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                sb.check_pose(m_axis_tdata);
            end
            if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready)) begin
                quiet_cycles <= 0;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
            if (quiet_cycles > STALL_LIMIT) begin
                $display("arc_odometry_pose_integrator verification failed");
                $finish;
            end
        end
    end

    // one input beat; entered and left just after a rising edge
    task automatic send_tick(tick_t t);
        while (!calm_tx && $urandom_range(99) < 27) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'd0, t.elapsed_us, t.heading_delta, t.forward_delta,
                          t.side_delta};
        s_axis_tuser  <= t.bad_reading;
        do @(negedge i_clk); while (!s_axis_tready);
        sb.note_tick(t);
        @(posedge i_clk);
    endtask

    // offsets change only with the block drained
    task automatic write_offsets(logic [23:0] side, logic [23:0] fwd);
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= REG_SIDE_OFFSET;
        i_cfg_data <= side;
        sb.set_offset(REG_SIDE_OFFSET, side);
        @(posedge i_clk);
        i_cfg_idx  <= REG_FORWARD_OFFSET;
        i_cfg_data <= fwd;
        sb.set_offset(REG_FORWARD_OFFSET, fwd);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic tick_t mk_tick(logic [31:0] sd, logic [31:0] fd, logic [31:0] hd,
                                      logic [19:0] dt, logic bad);
        tick_t t;
        t.side_delta    = sd;
        t.forward_delta = fd;
        t.heading_delta = hd;
        t.elapsed_us    = dt;
        t.bad_reading   = bad;
        return t;
    endfunction

    // mostly plausible robot motion, some full-range noise and special cases
    function automatic tick_t random_tick();
        tick_t t;
        int    mode;
        mode = $urandom_range(99);
        if (mode < 60) begin
            t.side_delta    = 32'($signed($urandom_range(2097152)) - 1048576);
            t.forward_delta = 32'($signed($urandom_range(2097152)) - 1048576);
            t.heading_delta = 32'($signed($urandom_range(134217728)) - 67108864);
            t.elapsed_us    = 20'($urandom_range(20000, 1));
        end else begin
            t.side_delta    = $urandom();
            t.forward_delta = $urandom();
            t.heading_delta = $urandom();
            t.elapsed_us    = 20'($urandom());
        end
        if ($urandom_range(99) < 3) t.heading_delta = 32'h8000_0000;
        if ($urandom_range(99) < 3) t.elapsed_us = '0;
        t.bad_reading = ($urandom_range(99) < 8);
        return t;
    endfunction

    initial begin
        tick_t directed[$];
        logic [23:0] side_set[5];
        logic [23:0] fwd_set[5];

        sb = new();
        calm_tx       = 1'b0;
        calm_rx       = 1'b0;
        quiet_cycles  = 0;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        m_axis_tready = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = REG_SIDE_OFFSET;
        i_cfg_data    = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: field extremes, half/quarter turns, time corners, bad flag
        directed.push_back(mk_tick(0, 0, 0, 1000, 0));
        directed.push_back(mk_tick(32'h0001_0000, 32'h0001_0000, 0, 1000, 0));
        directed.push_back(mk_tick(32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 1, 0));
        directed.push_back(mk_tick(32'h8000_0000, 32'h8000_0000, 0, 1, 0));
        directed.push_back(mk_tick(32'h0010_0000, 32'h0020_0000, 32'h4000_0000, 5000, 0));
        directed.push_back(mk_tick(32'h0010_0000, 32'h0020_0000, 32'hC000_0000, 5000, 0));
        directed.push_back(mk_tick(32'h0001_0000, 32'h0001_0000, 32'h8000_0000, 10000, 0));
        directed.push_back(mk_tick(32'h0001_0000, 32'h0001_0000, 32'h7FFF_FFFF, 10000, 0));
        directed.push_back(mk_tick(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 20'hFFFFF, 0));
        directed.push_back(mk_tick(32'h1234_5678, 32'h7FFF_FFFF, 32'h0100_0000, 0, 0));
        directed.push_back(mk_tick(32'h1234_5678, 32'h7FFF_FFFF, 32'h0100_0000, 1000000, 0));
        directed.push_back(mk_tick(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 1, 1));
        directed.push_back(mk_tick(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 0, 1));
        directed.push_back(mk_tick(32'h8000_0000, 32'h7FFF_FFFF, 32'h2000_0000, 1, 0));
        foreach (directed[i]) send_tick(directed[i]);

        // offset settings: range extremes, full 24-bit extremes, mixed
        side_set[0] = 24'd4194304;  fwd_set[0] = 24'($signed(-4194304));
        side_set[1] = 24'($signed(-4194304)); fwd_set[1] = 24'd4194304;
        side_set[2] = 24'h7FFFFF;   fwd_set[2] = 24'h800000;
        side_set[3] = 24'h0A0000;   fwd_set[3] = 24'hFC0000;
        side_set[4] = 24'($urandom()); fwd_set[4] = 24'($urandom());

        for (int ph = 0; ph < 5; ph++) begin
            write_offsets(side_set[ph], fwd_set[ph]);
            // a few directed turns under each offset
            send_tick(mk_tick(32'h0001_0000, 32'h0001_0000, 32'h8000_0000, 1000, 0));
            send_tick(mk_tick(0, 0, 32'h4000_0000, 1000, 0));
            for (int n = 0; n < 325; n++) begin
                calm_tx = (ph == 2) && (n < 120);
                calm_rx = (ph == 2) && (n < 120);
                send_tick(random_tick());
            end
            calm_tx = 1'b0;
            calm_rx = 1'b0;
        end

        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("arc_odometry_pose_integrator verification clean");
        end else begin
            $display("arc_odometry_pose_integrator verification failed");
        end
        $finish;
    end

endmodule
